>>> rtl/tcpq_pkg.sv
`timescale 1ns / 1ps
// tcpq_pkg: widths, screen geometry and the fixed 16-colour palette
// for the text cell palette quantiser; used by every rtl file
package tcpq_pkg;

   // screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;

   // field widths
   localparam int COLUMN_W = 7;
   localparam int ROW_W    = 5;
   localparam int CHAR_W   = 8;
   localparam int RGB_W    = 24;
   localparam int OFFSET_W = 12;
   localparam int ATTR_W   = 8;

   // palette and distance sizing
   localparam int CHAN_W   = 8;
   localparam int PAL_SIZE = 16;
   localparam int IDX_W    = $clog2(PAL_SIZE);
   localparam int DIST_W   = $clog2(3 * (2 ** CHAN_W - 1) + 1);

   // cell index is kept to one bit less than the offset, the offset being twice it
   localparam int CELL_W   = OFFSET_W - 1;

   typedef logic [COLUMN_W-1:0] column_type;
   typedef logic [ROW_W-1:0]    row_type;
   typedef logic [CHAR_W-1:0]   char_type;
   typedef logic [RGB_W-1:0]    rgb_type;
   typedef logic [OFFSET_W-1:0] offset_type;
   typedef logic [ATTR_W-1:0]   attr_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [DIST_W-1:0]   dist_type;
   typedef logic [CHAN_W-1:0]   chan_type;

   // standard 16-colour text palette, 0xRRGGBB
   localparam rgb_type PALETTE [PAL_SIZE] = '{
      24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
      24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
      24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
      24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
   };

   // absolute difference of two colour channels
   function automatic chan_type abs_diff(input chan_type p, input chan_type q);
      return (p > q) ? (p - q) : (q - p);
   endfunction

   // sum of absolute channel differences between a colour and a palette entry
   function automatic dist_type rgb_dist(input rgb_type c, input rgb_type e);
      dist_type dr;
      dist_type dg;
      dist_type db;
      dr = DIST_W'(abs_diff(c[23:16], e[23:16]));
      dg = DIST_W'(abs_diff(c[15:8],  e[15:8]));
      db = DIST_W'(abs_diff(c[7:0],   e[7:0]));
      return dr + dg + db;
   endfunction

endpackage

>>> rtl/tcpq_if.sv
`timescale 1ns / 1ps
// tcpq_req_if and tcpq_rsp_if: valid/ready channels of the quantiser
// depends on tcpq_pkg for the payload types
interface tcpq_req_if;
   import tcpq_pkg::*;

   logic       valid;
   logic       ready;
   column_type column;
   row_type    row;
   char_type   char_code;
   rgb_type    fore_rgb;
   rgb_type    back_rgb;

   modport source (output valid, column, row, char_code, fore_rgb, back_rgb,
                   input ready);
   modport sink   (input valid, column, row, char_code, fore_rgb, back_rgb,
                   output ready);
endinterface

interface tcpq_rsp_if;
   import tcpq_pkg::*;

   logic       valid;
   logic       ready;
   offset_type byte_offset;
   char_type   char_byte;
   attr_type   attr_byte;

   modport source (output valid, byte_offset, char_byte, attr_byte, input ready);
   modport sink   (input valid, byte_offset, char_byte, attr_byte, output ready);
endinterface

>>> rtl/text_cell_palette_quantizer.sv
`timescale 1ns / 1ps
// text_cell_palette_quantizer: maps a text-cell write to its memory offset,
// character and attribute; depends on tcpq_pkg, tcpq_if, tcpq_nearest
//
//   channel   direction  beat contents
//   req_chan  in         column, row, char_code, fore_rgb, back_rgb
//   rsp_chan  out        byte_offset, char_byte, attr_byte
//
// one beat per clock sustained unless rsp_chan stalls; each request beat passes
// through the input register, then the result register
// the palette search is a 16-way distance compare and a four-level minimum tree
// between the two registers
// reset clears only the valid flags; a stalled result holds and the input
// register keeps accepting while the result register is free to move
module text_cell_palette_quantizer (
   input logic       clock,
   input logic       reset,
   tcpq_req_if.sink  req_chan,
   tcpq_rsp_if.source rsp_chan
);
   import tcpq_pkg::*;

   logic       in_valid_ff,  in_valid_in;
   column_type column_ff;
   row_type    row_ff;
   char_type   char_ff;
   rgb_type    fore_ff;
   rgb_type    back_ff;

   logic       out_valid_ff, out_valid_in;
   offset_type offset_ff,    offset_in;
   char_type   char_out_ff;
   attr_type   attr_ff,      attr_in;

   logic       out_advance;
   logic       req_take;
   logic [CELL_W-1:0] cell_index;
   idx_type    fore_idx;
   idx_type    back_idx;

   // handshake
   assign out_advance    = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || out_advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = req_chan.ready ? req_chan.valid : in_valid_ff;
      out_valid_in = out_advance ? in_valid_ff : out_valid_ff;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         column_ff <= req_chan.column;
         row_ff    <= req_chan.row;
         char_ff   <= req_chan.char_code;
         fore_ff   <= req_chan.fore_rgb;
         back_ff   <= req_chan.back_rgb;
      end
   end

   // cell offset, wrapped to the offset width
   assign cell_index = CELL_W'(CELL_W'(row_ff) * CELL_W'(COLUMNS)) + CELL_W'(column_ff);
   assign offset_in  = {cell_index, 1'b0};

   // palette search for both colours
   tcpq_nearest u_fore_nearest (
      .rgb  (fore_ff),
      .pick (fore_idx)
   );

   tcpq_nearest u_back_nearest (
      .rgb  (back_ff),
      .pick (back_idx)
   );

   assign attr_in = {back_idx, fore_idx};

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (out_advance && in_valid_ff) begin
         offset_ff   <= offset_in;
         char_out_ff <= char_ff;
         attr_ff     <= attr_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.byte_offset = offset_ff;
   assign rsp_chan.char_byte   = char_out_ff;
   assign rsp_chan.attr_byte   = attr_ff;

endmodule

>>> rtl/tcpq_nearest.sv
`timescale 1ns / 1ps
// tcpq_nearest: picks the nearest palette entry to a 24-bit colour
// by sum of absolute channel differences; depends on tcpq_pkg
module tcpq_nearest (
   input  tcpq_pkg::rgb_type rgb,
   output tcpq_pkg::idx_type pick
);
   import tcpq_pkg::*;

   dist_type dist_l0 [16];
   dist_type dist_l1 [8];
   dist_type dist_l2 [4];
   dist_type dist_l3 [2];
   idx_type  idx_l1  [8];
   idx_type  idx_l2  [4];
   idx_type  idx_l3  [2];

   // distance to every entry in parallel
   always_comb begin
      for (int k = 0; k < PAL_SIZE; k++) begin
         dist_l0[k] = rgb_dist(rgb, PALETTE[k]);
      end
   end

   // minimum tree, left side kept on a tie so the lower index wins
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         if (dist_l0[2*k] <= dist_l0[2*k+1]) begin
            dist_l1[k] = dist_l0[2*k];
            idx_l1[k]  = IDX_W'(2*k);
         end else begin
            dist_l1[k] = dist_l0[2*k+1];
            idx_l1[k]  = IDX_W'(2*k+1);
         end
      end
      for (int k = 0; k < 4; k++) begin
         if (dist_l1[2*k] <= dist_l1[2*k+1]) begin
            dist_l2[k] = dist_l1[2*k];
            idx_l2[k]  = idx_l1[2*k];
         end else begin
            dist_l2[k] = dist_l1[2*k+1];
            idx_l2[k]  = idx_l1[2*k+1];
         end
      end
      for (int k = 0; k < 2; k++) begin
         if (dist_l2[2*k] <= dist_l2[2*k+1]) begin
            dist_l3[k] = dist_l2[2*k];
            idx_l3[k]  = idx_l2[2*k];
         end else begin
            dist_l3[k] = dist_l2[2*k+1];
            idx_l3[k]  = idx_l2[2*k+1];
         end
      end
      pick = (dist_l3[0] <= dist_l3[1]) ? idx_l3[0] : idx_l3[1];
   end

endmodule
